// ===== design/imq_pkg.sv =====
// Shared constants and types for the indexed max priority queue.
package imq_pkg;

  localparam int unsigned ENTRIES  = 64;
  localparam int unsigned IDX_W    = $clog2(ENTRIES);
  localparam int unsigned ID_W     = 6;
  localparam int unsigned PRI_W    = 16;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned SLOT_W   = PRI_W + STAMP_W;
  localparam int unsigned S_DATA_W = 24;
  localparam int unsigned M_DATA_W = 24;

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_INCREASE = 2'd1,
    ACT_REMOVE   = 2'd2,
    ACT_QUERY    = 2'd3
  } action_e;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [PRI_W-1:0]   priority_val;
  } slot_t;

endpackage

// ===== design/imq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module imq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/imq_cmp.sv =====
// Shared compare unit: is the candidate slot better than the current best.
module imq_cmp (
  input  logic                        cand_valid_i,
  input  imq_pkg::slot_t              cand_i,
  input  logic                        best_found_i,
  input  imq_pkg::slot_t              best_i,
  output logic                        better_o
);

  logic pri_gt;
  logic pri_eq;
  logic stamp_lt;

  assign pri_gt   = cand_i.priority_val > best_i.priority_val;
  assign pri_eq   = cand_i.priority_val == best_i.priority_val;
  assign stamp_lt = cand_i.stamp < best_i.stamp;
  assign better_o = cand_valid_i && (!best_found_i || pri_gt || (pri_eq && stamp_lt));

endmodule

// ===== design/indexed_max_priority_queue.sv =====
// Indexed max priority queue: top level with sequencer, slot RAM and scan.
// Insert and remove act on the transfer; increase does a read-modify-write of the slot RAM in S_INC.
// A query holds the input while it scans every slot in S_SCAN, one RAM read and compare per
// slot, then passes S_LAST and registers its result in S_EMIT once the output is free.
// Input is not ready during an increase or query; a held result delays only a later query.
// Reset (rst_ni, async low) clears all valid bits, the item count and the sequencer.
module indexed_max_priority_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [imq_pkg::S_DATA_W-1:0] s_axis_tdata,  // entry_id[5:0], amount[21:6], zero pad
  input  logic [1:0]                   s_axis_tuser,  // action[1:0]
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [imq_pkg::M_DATA_W-1:0] m_axis_tdata,  // top_id[5:0], top_priority[21:6], zero pad
  output logic                         m_axis_tuser   // is_empty
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INC,
    S_SCAN,
    S_LAST,
    S_EMIT
  } state_e;

  state_e state_q;

  logic [imq_pkg::ENTRIES-1:0] valid_q;
  logic [imq_pkg::STAMP_W-1:0] count_q;

  logic [imq_pkg::IDX_W-1:0]   scan_q;
  logic                        cmp_vld_q;
  logic [imq_pkg::IDX_W-1:0]   cmp_idx_q;

  logic [imq_pkg::IDX_W-1:0]   inc_idx_q;
  logic [imq_pkg::PRI_W-1:0]   inc_amt_q;
  logic                        inc_ok_q;

  logic                        found_q;
  logic [imq_pkg::IDX_W-1:0]   best_idx_q;
  imq_pkg::slot_t              best_q;

  logic                        out_valid_q;
  logic                        out_empty_q;
  logic [imq_pkg::ID_W-1:0]    out_id_q;
  logic [imq_pkg::PRI_W-1:0]   out_pri_q;

  imq_pkg::action_e            in_act;
  logic [imq_pkg::ID_W-1:0]    in_id;
  logic [imq_pkg::PRI_W-1:0]   in_amt;
  logic [imq_pkg::IDX_W-1:0]   in_idx;
  logic                        in_range;
  logic                        in_fire;

  logic                        ram_we;
  logic [imq_pkg::IDX_W-1:0]   ram_waddr;
  imq_pkg::slot_t              ram_wdata;
  logic [imq_pkg::IDX_W-1:0]   ram_raddr;
  imq_pkg::slot_t              ram_rdata;

  logic [imq_pkg::PRI_W:0]     inc_sum;
  logic [imq_pkg::PRI_W-1:0]   inc_sat;
  logic                        better;
  logic                        out_free;

  assign in_act   = imq_pkg::action_e'(s_axis_tuser);
  assign in_id    = s_axis_tdata[imq_pkg::ID_W-1:0];
  assign in_amt   = s_axis_tdata[imq_pkg::ID_W +: imq_pkg::PRI_W];
  assign in_idx   = imq_pkg::IDX_W'(in_id);
  assign in_range = 32'(in_id) < imq_pkg::ENTRIES;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign inc_sum = {1'b0, ram_rdata.priority_val} + {1'b0, inc_amt_q};
  assign inc_sat = inc_sum[imq_pkg::PRI_W] ? '1 : inc_sum[imq_pkg::PRI_W-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_idx;
    ram_wdata = '{stamp: count_q, priority_val: in_amt};
    ram_raddr = in_idx;
    if (state_q == S_SCAN) begin
      ram_raddr = scan_q;
    end
    if (state_q == S_INC) begin
      ram_we    = inc_ok_q;
      ram_waddr = inc_idx_q;
      ram_wdata = '{stamp: ram_rdata.stamp, priority_val: inc_sat};
    end else if (in_fire && in_act == imq_pkg::ACT_INSERT && in_range) begin
      ram_we = 1'b1;
    end
  end

  imq_ram #(
    .WIDTH(imq_pkg::SLOT_W),
    .DEPTH(imq_pkg::ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  imq_cmp u_cmp (
    .cand_valid_i(cmp_vld_q && valid_q[cmp_idx_q]),
    .cand_i      (ram_rdata),
    .best_found_i(found_q),
    .best_i      (best_q),
    .better_o    (better)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      count_q     <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_empty_q <= 1'b0;
      out_id_q    <= '0;
      out_pri_q   <= '0;
    end else begin
      cmp_vld_q <= (state_q == S_SCAN);
      if (out_valid_q && m_axis_tready && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire && count_q != '1) begin
        count_q <= count_q + 1'b1;
      end
      if (better) begin
        found_q <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_act)
              imq_pkg::ACT_INSERT: begin
                if (in_range) begin
                  valid_q[in_idx] <= 1'b1;
                end
              end
              imq_pkg::ACT_INCREASE: state_q <= S_INC;
              imq_pkg::ACT_REMOVE: begin
                if (in_range) begin
                  valid_q[in_idx] <= 1'b0;
                end
              end
              imq_pkg::ACT_QUERY: begin
                found_q <= 1'b0;
                state_q <= S_SCAN;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_INC: state_q <= S_IDLE;
        S_SCAN: begin
          if (scan_q == imq_pkg::IDX_W'(imq_pkg::ENTRIES - 1)) begin
            state_q <= S_LAST;
          end
        end
        S_LAST: state_q <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_empty_q <= !found_q;
            out_id_q    <= imq_pkg::ID_W'(best_idx_q);
            out_pri_q   <= best_q.priority_val;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= scan_q;
    if (state_q == S_SCAN) begin
      scan_q <= scan_q + 1'b1;
    end
    if (in_fire) begin
      scan_q     <= '0;
      inc_idx_q  <= in_idx;
      inc_amt_q  <= in_amt;
      inc_ok_q   <= in_range && valid_q[in_idx];
      best_idx_q <= '0;
      best_q     <= '0;
    end
    if (better) begin
      best_idx_q <= cmp_idx_q;
      best_q     <= ram_rdata;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_empty_q;
  assign m_axis_tdata  = imq_pkg::M_DATA_W'({out_pri_q, out_id_q});

endmodule

// ===== design/imq_chk.sv =====
// Port-level assertions for the indexed max priority queue, bound to the top level.
module imq_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [1:0]                   s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [imq_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic                         m_axis_tuser
);

  logic query_fire;

  assign query_fire = s_axis_tvalid && s_axis_tready &&
                      (s_axis_tuser == imq_pkg::ACT_QUERY);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("empty result carries nonzero data");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_fire |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input ready during scan");

endmodule

bind indexed_max_priority_queue imq_chk u_imq_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for indexed_max_priority_queue: random and directed actions checked by a scoreboard.
module testbench;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 100;
  localparam int PHASE_ITEMS = 475;

  typedef struct packed {
    logic                      is_empty;
    logic [imq_pkg::ID_W-1:0]  id;
    logic [imq_pkg::PRI_W-1:0] pri;
  } top_t;

  class pq_shadow;
    logic                        slot_live  [imq_pkg::ENTRIES];
    logic [imq_pkg::PRI_W-1:0]   slot_pri   [imq_pkg::ENTRIES];
    logic [imq_pkg::STAMP_W-1:0] slot_stamp [imq_pkg::ENTRIES];
    logic [imq_pkg::STAMP_W-1:0] items_seen;
    top_t                        pending_tops [$];
    int                          errors;

    function new();
      for (int k = 0; k < imq_pkg::ENTRIES; k++) begin
        slot_live[k]  = 1'b0;
        slot_pri[k]   = '0;
        slot_stamp[k] = '0;
      end
      items_seen = '0;
      errors     = 0;
    endfunction

    function top_t predict_top();
      top_t best;
      logic [imq_pkg::STAMP_W-1:0] best_stamp;
      logic found;
      best       = '0;
      best_stamp = '0;
      found      = 1'b0;
      for (int k = 0; k < imq_pkg::ENTRIES; k++) begin
        if (slot_live[k] && (!found || slot_pri[k] > best.pri ||
            (slot_pri[k] == best.pri && slot_stamp[k] < best_stamp))) begin
          found      = 1'b1;
          best.id    = imq_pkg::ID_W'(k);
          best.pri   = slot_pri[k];
          best_stamp = slot_stamp[k];
        end
      end
      if (!found) begin
        best          = '0;
        best.is_empty = 1'b1;
      end
      return best;
    endfunction

    function void take_item(imq_pkg::action_e act, logic [imq_pkg::ID_W-1:0] id,
                            logic [imq_pkg::PRI_W-1:0] amount);
      logic [imq_pkg::PRI_W:0] sum;
      case (act)
        imq_pkg::ACT_INSERT: begin
          slot_live[id]  = 1'b1;
          slot_pri[id]   = amount;
          slot_stamp[id] = items_seen;
        end
        imq_pkg::ACT_INCREASE: begin
          if (slot_live[id]) begin
            sum = {1'b0, slot_pri[id]} + {1'b0, amount};
            slot_pri[id] = sum[imq_pkg::PRI_W] ? {imq_pkg::PRI_W{1'b1}} :
                                                 sum[imq_pkg::PRI_W-1:0];
          end
        end
        imq_pkg::ACT_REMOVE: slot_live[id] = 1'b0;
        default: pending_tops.push_back(predict_top());
      endcase
      if (items_seen != {imq_pkg::STAMP_W{1'b1}}) items_seen++;
    endfunction

    function void check_top(top_t got);
      top_t want;
      if (pending_tops.size() == 0) begin
        $display("%0t: unexpected result transfer, actual empty=%0d id=%0d pri=%0d",
                 $time, got.is_empty, got.id, got.pri);
        errors++;
        return;
      end
      want = pending_tops.pop_front();
      if (got.is_empty !== want.is_empty) begin
        $display("%0t: is_empty expected %0d actual %0d", $time, want.is_empty, got.is_empty);
        errors++;
      end
      if (got.id !== want.id) begin
        $display("%0t: top_id expected %0d actual %0d", $time, want.id, got.id);
        errors++;
      end
      if (got.pri !== want.pri) begin
        $display("%0t: top_priority expected %0d actual %0d", $time, want.pri, got.pri);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [imq_pkg::S_DATA_W-1:0] s_axis_tdata;
  logic [1:0]                   s_axis_tuser;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [imq_pkg::M_DATA_W-1:0] m_axis_tdata;
  logic                         m_axis_tuser;

  pq_shadow shadow;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       quiet_cycles;

  indexed_max_priority_queue uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        shadow.check_top({m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[21:6]});
      end
      if (s_axis_tvalid && s_axis_tready) begin
        shadow.take_item(imq_pkg::action_e'(s_axis_tuser), s_axis_tdata[5:0],
                         s_axis_tdata[21:6]);
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Called just after a falling edge; returns just after the falling edge following the transfer.
  task automatic send_item(imq_pkg::action_e act, logic [imq_pkg::ID_W-1:0] id,
                           logic [imq_pkg::PRI_W-1:0] amount);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {2'b00, amount, id};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_random(int n);
    int r;
    logic [imq_pkg::ID_W-1:0]  id;
    logic [imq_pkg::PRI_W-1:0] amount;
    imq_pkg::action_e act;
    r = $urandom_range(99);
    // alternate between filling and draining stretches so the table both grows and empties
    if ((n / 80) % 2 == 0) begin
      act = (r < 40) ? imq_pkg::ACT_INSERT : (r < 60) ? imq_pkg::ACT_INCREASE :
            (r < 75) ? imq_pkg::ACT_REMOVE : imq_pkg::ACT_QUERY;
    end else begin
      act = (r < 15) ? imq_pkg::ACT_INSERT : (r < 30) ? imq_pkg::ACT_INCREASE :
            (r < 75) ? imq_pkg::ACT_REMOVE : imq_pkg::ACT_QUERY;
    end
    id = ($urandom_range(99) < 60) ? imq_pkg::ID_W'($urandom_range(7)) :
                                     imq_pkg::ID_W'($urandom_range(63));
    r = $urandom_range(99);
    if (r < 40) begin
      amount = imq_pkg::PRI_W'($urandom_range(3));
    end else if (r < 60) begin
      amount = imq_pkg::PRI_W'($urandom_range(65535, 65000));
    end else begin
      amount = imq_pkg::PRI_W'($urandom_range(65535));
    end
    send_item(act, id, amount);
  endtask

  initial begin
    shadow         = new();
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = imq_pkg::ACT_INSERT;
    m_axis_tready  = 1'b1;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty table, absent entries, extremes, saturation, ties and reinsert
    send_item(imq_pkg::ACT_QUERY,    6'd63, 16'hFFFF);
    send_item(imq_pkg::ACT_REMOVE,   6'd7,  16'd0);
    send_item(imq_pkg::ACT_INCREASE, 6'd7,  16'd5);
    send_item(imq_pkg::ACT_QUERY,    6'd0,  16'd0);
    send_item(imq_pkg::ACT_INSERT,   6'd0,  16'd0);
    send_item(imq_pkg::ACT_QUERY,    6'd0,  16'd0);
    send_item(imq_pkg::ACT_INSERT,   6'd63, 16'hFFFF);
    send_item(imq_pkg::ACT_QUERY,    6'd21, 16'h5555);
    send_item(imq_pkg::ACT_INCREASE, 6'd63, 16'd1);
    send_item(imq_pkg::ACT_INSERT,   6'd10, 16'hFFFF);
    send_item(imq_pkg::ACT_QUERY,    6'd42, 16'hAAAA);
    send_item(imq_pkg::ACT_INSERT,   6'd63, 16'hFFFF);
    send_item(imq_pkg::ACT_QUERY,    6'd0,  16'd0);
    send_item(imq_pkg::ACT_INCREASE, 6'd0,  16'hFFFF);
    send_item(imq_pkg::ACT_INCREASE, 6'd0,  16'd0);
    send_item(imq_pkg::ACT_QUERY,    6'd0,  16'd0);
    send_item(imq_pkg::ACT_REMOVE,   6'd0,  16'd0);
    send_item(imq_pkg::ACT_REMOVE,   6'd10, 16'd0);
    send_item(imq_pkg::ACT_REMOVE,   6'd63, 16'd0);
    send_item(imq_pkg::ACT_QUERY,    6'd0,  16'd0);
    send_item(imq_pkg::ACT_INSERT,   6'd42, 16'hAAAA);
    send_item(imq_pkg::ACT_INCREASE, 6'd42, 16'h5555);
    send_item(imq_pkg::ACT_INCREASE, 6'd42, 16'hFFFF);
    send_item(imq_pkg::ACT_QUERY,    6'd0,  16'd0);
    send_item(imq_pkg::ACT_REMOVE,   6'd42, 16'd0);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 56 : (phase == 3) ? 14 : 0;
      recv_stall_pct = (phase == 2) ? 56 : (phase == 3) ? 14 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random(n);
    end
    s_axis_tvalid <= 1'b0;

    while (shadow.pending_tops.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (shadow.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/imq_pkg.sv
design/imq_ram.sv
design/imq_cmp.sv
design/indexed_max_priority_queue.sv
design/imq_chk.sv
test/testbench.sv
